@@ rtl/fpec_pkg.sv @@
// ----------------------------------------------------------------------------
// fpec_pkg: shared types and constants of the float / wire-word codec
// Field widths of the wire word and the operation codes.
// ----------------------------------------------------------------------------
package fpec_pkg;

	localparam int unsigned MantW   = 26;
	localparam int unsigned ExpW    = 32 - MantW;
	localparam int unsigned Ms      = MantW - 1;
	localparam int unsigned WordW   = 32;

	typedef enum logic {
		ACT_ENCODE = 1'b0,
		ACT_DECODE = 1'b1
	} action_t;

	typedef struct packed {
		logic        action;
		logic [31:0] value;
	} fpec_in_t;

	typedef struct packed {
		logic [31:0] result;
		logic        special;
	} fpec_out_t;

endpackage

@@ rtl/fpec_stream_if.sv @@
// ----------------------------------------------------------------------------
// fpec_stream_if: valid/ready channel
// Carries one word of type T per handshake.
// ----------------------------------------------------------------------------
interface fpec_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/fpec_pipe.sv @@
// ----------------------------------------------------------------------------
// fpec_pipe: three-stage conversion datapath
// Stage 1 decodes fields, stage 2 shifts/rounds, stage 3 packs the result.
// All stages advance together when the output is free or empty.
// ----------------------------------------------------------------------------
module fpec_pipe (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fpec_pkg::fpec_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output fpec_pkg::fpec_out_t out_data
);
	import fpec_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic adv;

	// stage 1 payload
	logic        act_s1, sgn_s1, nan_s1, neg_s1, sat_s1, zero_s1;
	logic [5:0]  e_s1;
	logic [23:0] sig_s1;
	logic [5:0]  rsh_s1;
	logic        lsh_s1;
	logic [24:0] dm_s1;
	logic [5:0]  dexp_s1;

	// stage 2 payload
	logic        act_s2, nan_s2, neg_s2, zero_s2;
	logic [5:0]  e_s2;
	logic [24:0] mant_s2;
	logic [23:0] dsig_s2;
	logic [4:0]  lz_s2;
	logic [6:0]  dexp_s2;

	// stage 3 payload
	fpec_out_t   out_s3;

	// advance whole pipe when the last stage is empty or being taken
	assign adv      = !v_s3 || out_ready;
	assign in_ready = adv;
	assign out_valid = v_s3;
	assign out_data  = out_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: field split, exponent and shift amount
	logic [7:0] be;
	logic [22:0] fr;
	logic [8:0] ex9;
	logic [8:0] shn;
	always_comb begin
		be  = in_data.value[30:23];
		fr  = in_data.value[22:0];
		ex9 = (be >= 8'd126) ? ({1'b0, be} - 9'd126) : 9'd0;
		// negative of sh = be-125-ex
		shn = ex9 + 9'd125 - {1'b0, be};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1  <= in_data.action;
			sgn_s1  <= in_data.value[25];
			nan_s1  <= (be == 8'hFF) && (fr != '0);
			neg_s1  <= in_data.value[31] && (in_data.value[30:0] != '0);
			sat_s1  <= (be == 8'hFF) || (ex9 > 9'd63);
			zero_s1 <= (be == 8'd0);
			e_s1    <= ex9[5:0];
			sig_s1  <= {1'b1, fr};
			lsh_s1  <= shn[8];
			rsh_s1  <= (shn[8] || shn >= 9'd31) ? 6'd31 : shn[5:0];
			dm_s1   <= in_data.value[24:0];
			dexp_s1 <= in_data.value[31:26];
		end
	end

	// stage 2: encode shift, decode rounding and leading-zero count
	logic [24:0] emant;
	logic [23:0] rnd;
	logic        rcar;
	logic [24:0] rsum;
	logic [6:0]  dpe;
	logic [4:0]  lz;
	always_comb begin
		if (lsh_s1) emant = {sig_s1, 1'b0};
		else if (rsh_s1 >= 6'd31) emant = '0;
		else emant = {1'b0, sig_s1} >> rsh_s1[4:0];
		rsum = '0;
		rcar = 1'b0;
		dpe  = {1'b0, dexp_s1};
		rnd  = dm_s1[23:0];
		if (dm_s1[24]) begin
			rsum = {1'b0, dm_s1[24:1]} + {24'd0, dm_s1[0] & dm_s1[1]};
			rcar = rsum[24];
			rnd  = rcar ? rsum[24:1] : rsum[23:0];
			dpe  = {1'b0, dexp_s1} + (rcar ? 7'd2 : 7'd1);
		end
		// highest set bit wins
		lz = 5'd0;
		for (int i = 0; i <= 23; i++) begin
			if (rnd[i]) lz = 5'(23 - i);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s2  <= act_s1;
			nan_s2  <= nan_s1;
			neg_s2  <= (act_s1 == ACT_DECODE) ? sgn_s1 : neg_s1;
			zero_s2 <= (act_s1 == ACT_DECODE) ? (dm_s1 == '0) : 1'b0;
			e_s2    <= (sat_s1 || zero_s1) ? (sat_s1 ? 6'd63 : 6'd0) : e_s1;
			mant_s2 <= sat_s1 ? 25'h1FFFFFF : (zero_s1 ? 25'd0 : emant);
			dsig_s2 <= rnd;
			lz_s2   <= lz;
			dexp_s2 <= dpe;
		end
	end

	// stage 3: normalize decode and pack
	logic [23:0] nsig;
	logic [7:0]  dbe;
	always_comb begin
		nsig = dsig_s2 << lz_s2;
		// biased exponent = pe - 25 - lz + 150
		dbe  = 8'({1'b0, dexp_s2} + 8'd125 - {3'd0, lz_s2});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (act_s2 == ACT_DECODE) begin
				out_s3.special <= 1'b0;
				out_s3.result  <= zero_s2 ? {neg_s2, 31'd0} : {neg_s2, dbe, nsig[22:0]};
			end else begin
				out_s3.special <= nan_s2;
				out_s3.result  <= nan_s2 ? 32'd0 : {e_s2, neg_s2, mant_s2};
			end
		end
	end

endmodule

@@ rtl/float_to_packed_exp_mant_codec.sv @@
// ----------------------------------------------------------------------------
// float_to_packed_exp_mant_codec: float / wire-word converter
// Top level; wraps the conversion pipeline onto stream interfaces.
// ----------------------------------------------------------------------------
// Usage:
//   s_in carries {action, value}; action 0 encodes IEEE single bits into
//   the 6/1/25 wire word, action 1 decodes a wire word into single bits.
//   m_out carries {result, special}; special flags a NaN replaced by zero.
//   An accepted word is registered in stage 1, stage 2 and stage 3 in turn;
//   output valid rises once it sits in stage 3. One word per cycle is
//   sustained while the receiver keeps up; the three stages advance as one.
//   When the receiver stalls, all stages hold and input ready drops while
//   the output stage is full and not taken; nothing is lost or repeated.
//   Reset clears all stage valid bits; the block is ready right after.
// ----------------------------------------------------------------------------
module float_to_packed_exp_mant_codec (
	input  logic clk,
	input  logic arst_n,
	fpec_stream_if.sink   s_in,
	fpec_stream_if.source m_out
);
	import fpec_pkg::*;

	fpec_in_t  in_w;
	fpec_out_t out_w;

	assign in_w = s_in.data;
	assign m_out.data = out_w;

	fpec_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_in.valid),
		.in_ready  (s_in.ready),
		.in_data   (in_w),
		.out_valid (m_out.valid),
		.out_ready (m_out.ready),
		.out_data  (out_w)
	);

endmodule
